// ----- rtl/core/utf8_stream_decoder_top_defines.svh -----
// ---------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Concurrent checks that are compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property checked at every clock edge outside reset
`define USD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("usd assertion failed");
// antecedent in this cycle, consequent in the next
`define USD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("usd assertion failed");
`else
`define USD_ASSERT(lbl, prop)
`define USD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/core/usd_pkg.sv -----
// ---------------------------------------------------------------------------
// UTF-8 stream decoder package
// Result kinds, result and state types, first-byte decode helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package usd_pkg;

	localparam int CP_W    = 21;
	localparam int MAX_RES = 4;
	localparam int PEND_N  = 3;

	// result kinds
	localparam logic [1:0] KIND_CODEPOINT = 2'd0;
	localparam logic [1:0] KIND_RAW       = 2'd1;
	localparam logic [1:0] KIND_ERROR     = 2'd2;
	localparam logic [1:0] KIND_END       = 2'd3;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic [1:0]      kind;
	} res_t;

	// decoder control state
	typedef struct packed {
		logic [CP_W-1:0] acc;
		logic [1:0]      brem;
		logic [1:0]      pcnt;
		logic            drop;
	} dec_ctl_t;

	// sequence length from the first byte, zero for an invalid lead
	function automatic logic [2:0] seq_len(input logic [7:0] b);
		logic [2:0] len;
		case (b) inside
			[8'h00:8'h7F]: len = 3'd1;
			[8'hC0:8'hDF]: len = 3'd2;
			[8'hE0:8'hEF]: len = 3'd3;
			[8'hF0:8'hF7]: len = 3'd4;
			default:       len = 3'd0;
		endcase
		return len;
	endfunction

	// payload bits kept from a lead byte
	function automatic logic [7:0] lead_mask(input logic [2:0] len);
		logic [7:0] m;
		case (len)
			3'd1:    m = 8'h7F;
			3'd2:    m = 8'h1F;
			3'd3:    m = 8'h0F;
			3'd4:    m = 8'h07;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/utf8_stream_decoder_top.sv -----
// ---------------------------------------------------------------------------
// UTF-8 stream decoder
// Byte-in, codepoint-out decoder with raw-byte or abandon error handling.
// ---------------------------------------------------------------------------
// One byte is taken per transfer; a zero byte ends the string and yields an
// end result. Each byte yields zero to four results, held in a four-entry
// result buffer and handed out one per cycle while the output is not
// stalled, with last set on the final one. A byte is taken in the cycle the
// buffer empties, so the block runs at one byte per clock while each byte
// gives at most one result and the output is not stalled; a byte that gives
// more results holds off the next byte until its last result is taken. Under
// the abandon policy (policy register set to 1) an error result is followed by
// silence until the terminator and the whole string must be discarded.
`default_nettype none

module utf8_stream_decoder_top import usd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	// byte input
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          in_byte,
	// result output
	output logic                out_valid,
	input  logic                out_stall,
	output logic [CP_W-1:0]     codepoint,
	output logic [1:0]          kind,
	output logic                last
);

`include "utf8_stream_decoder_top_defines.svh"

	logic                      policy_q;
	dec_ctl_t                  ctl_q;
	logic [PEND_N-1:0][7:0]    pend_q;
	res_t [MAX_RES-1:0]        slot_q;
	logic [2:0]                rem_q;

	dec_ctl_t                  ctl_nxt;
	logic [PEND_N-1:0][7:0]    pend_nxt;
	res_t [MAX_RES-1:0]        res;
	logic [2:0]                res_n;
	logic                      in_xfer;
	logic                      out_xfer;

	// handshake
	assign out_valid = (rem_q != 3'd0);
	assign out_xfer  = out_valid && !out_stall;
	assign in_stall  = !((rem_q == 3'd0) || ((rem_q == 3'd1) && !out_stall));
	assign in_xfer   = in_valid && !in_stall;

	assign codepoint = slot_q[0].cp;
	assign kind      = slot_q[0].kind;
	assign last      = (rem_q == 3'd1);

	// step logic
	usd_decode u_dec (
		.ctl_cur  (ctl_q),
		.pend_cur (pend_q),
		.in_byte  (in_byte),
		.policy   (policy_q),
		.ctl_nxt  (ctl_nxt),
		.pend_nxt (pend_nxt),
		.res      (res),
		.res_n    (res_n)
	);

	// policy register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
		end else if (cfg_wr_en) begin
			policy_q <= cfg_wr_data;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (in_xfer) begin
			ctl_q <= ctl_nxt;
		end
	end

	// buffered sequence bytes, only read below the fill count
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pend_q <= pend_nxt;
		end
	end

	// result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (in_xfer) begin
			rem_q <= res_n;
		end else if (out_xfer) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	// result slots, head at entry 0
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			slot_q <= res;
		end else if (out_xfer) begin
			for (int i = 0; i < MAX_RES - 1; i++) begin
				slot_q[i] <= slot_q[i+1];
			end
		end
	end

	// checks
	`USD_ASSERT(a_rem_range, rem_q <= 3'd4)
	`USD_ASSERT(a_seq_fill, (ctl_q.brem != 2'd0) |->
		((ctl_q.pcnt != 2'd0) && ({1'b0, ctl_q.pcnt} + {1'b0, ctl_q.brem} <= 3'd4)))
	`USD_ASSERT(a_drop_idle, ctl_q.drop |-> (ctl_q.brem == 2'd0))
	`USD_ASSERT(a_end_last, (out_valid && (kind == KIND_END)) |-> last)
	`USD_ASSERT_NEXT(a_drain, out_xfer && last && !in_xfer, !out_valid)

endmodule

`default_nettype wire

// ----- rtl/core/usd_decode.sv -----
// ---------------------------------------------------------------------------
// UTF-8 stream decoder step logic
// Next state and the list of up to four results for one input byte.
// ---------------------------------------------------------------------------
`default_nettype none

module usd_decode import usd_pkg::*; (
	input  dec_ctl_t                  ctl_cur,
	input  logic [PEND_N-1:0][7:0]    pend_cur,
	input  logic [7:0]                in_byte,
	input  logic                      policy,
	output dec_ctl_t                  ctl_nxt,
	output logic [PEND_N-1:0][7:0]    pend_nxt,
	output res_t [MAX_RES-1:0]        res,
	output logic [2:0]                res_n
);

	logic            fb_run;
	logic [2:0]      len;
	logic [CP_W-1:0] acc_sh;
	logic            is_cont;

	assign len     = seq_len(in_byte);
	assign acc_sh  = {ctl_cur.acc[CP_W-7:0], in_byte[5:0]};
	assign is_cont = (in_byte != 8'h00) && (in_byte[7:6] == 2'b10);

	always_comb begin
		ctl_nxt  = ctl_cur;
		pend_nxt = pend_cur;
		res      = '0;
		res_n    = 3'd0;
		fb_run   = 1'b0;

		// sequence handling
		if (ctl_cur.drop) begin
			if (in_byte == 8'h00) begin
				ctl_nxt.drop = 1'b0;
				res[0]       = '{cp: '0, kind: KIND_END};
				res_n        = 3'd1;
			end
		end else if (ctl_cur.brem == 2'd0) begin
			fb_run = 1'b1;
		end else if (is_cont) begin
			ctl_nxt.acc  = acc_sh;
			ctl_nxt.brem = ctl_cur.brem - 2'd1;
			if (ctl_cur.brem == 2'd1) begin
				res[0]       = '{cp: acc_sh, kind: KIND_CODEPOINT};
				res_n        = 3'd1;
				ctl_nxt.pcnt = 2'd0;
			end else if (ctl_cur.pcnt != 2'd3) begin
				pend_nxt[ctl_cur.pcnt] = in_byte;
				ctl_nxt.pcnt           = ctl_cur.pcnt + 2'd1;
			end
		end else begin
			// broken sequence
			ctl_nxt.brem = 2'd0;
			ctl_nxt.pcnt = 2'd0;
			if (policy) begin
				res[0] = '{cp: '0, kind: KIND_ERROR};
				if (in_byte == 8'h00) begin
					res[1] = '{cp: '0, kind: KIND_END};
					res_n  = 3'd2;
				end else begin
					res_n        = 3'd1;
					ctl_nxt.drop = 1'b1;
				end
			end else begin
				for (int i = 0; i < PEND_N; i++) begin
					if (2'(i) < ctl_cur.pcnt) begin
						res[i] = '{cp: CP_W'(pend_cur[i]), kind: KIND_RAW};
					end
				end
				res_n  = {1'b0, ctl_cur.pcnt};
				fb_run = 1'b1;
			end
		end

		// current byte as a first byte
		if (fb_run) begin
			if (in_byte == 8'h00) begin
				res[res_n[1:0]] = '{cp: '0, kind: KIND_END};
				res_n           = res_n + 3'd1;
			end else if (len == 3'd0) begin
				if (policy) begin
					res[res_n[1:0]] = '{cp: '0, kind: KIND_ERROR};
					ctl_nxt.drop    = 1'b1;
				end else begin
					res[res_n[1:0]] = '{cp: CP_W'(in_byte), kind: KIND_RAW};
				end
				res_n = res_n + 3'd1;
			end else if (len == 3'd1) begin
				res[res_n[1:0]] = '{cp: CP_W'(in_byte), kind: KIND_CODEPOINT};
				res_n           = res_n + 3'd1;
			end else begin
				ctl_nxt.acc  = CP_W'(in_byte & lead_mask(len));
				ctl_nxt.brem = 2'(len - 3'd1);
				pend_nxt[0]  = in_byte;
				ctl_nxt.pcnt = 2'd1;
			end
		end
	end

endmodule

`default_nettype wire
